@@ design/trci_pkg.sv @@
// shared constants, widths and register codes of the cubic table reader
package trci_pkg;

   // fixed field widths
   localparam int FRAC_BITS   = 16;
   localparam int SAMPLE_BITS = 24;
   localparam int POS_BITS    = 29;
   localparam int PTS_BITS    = 13;
   localparam int WADDR_BITS  = 12;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 29;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_POINTS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ONSET        = 1'b1;

   // operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // default table size
   localparam int TABLE_DEPTH_DEF = 4096;

   // fixed point helpers
   localparam int FRAC_ONE  = 1 << FRAC_BITS;
   localparam int FRAC_HALF = 1 << (FRAC_BITS - 1);

   // datapath widths
   localparam int FW   = FRAC_BITS + 1;        // fraction 0 .. 1.0
   localparam int DW   = SAMPLE_BITS + 1;      // c - b
   localparam int PQW  = SAMPLE_BITS + 4;      // cubic coefficients
   localparam int P1W  = PQW + FW + 1;
   localparam int T1W  = SAMPLE_BITS + 5;
   localparam int P2W  = T1W + FW + 1;
   localparam int WW   = SAMPLE_BITS + 6;      // w and final sum
   localparam int P3W  = WW + FW + 1;
   localparam int UW   = WW;                   // biased dividend for divide by six

   // divide by six: floor(u * MAGIC6 / 2^MAGIC_SHIFT) exact for u below 2^32
   localparam logic [31:0] MAGIC6 = 32'hAAAA_AAAB;
   localparam int MAGIC_SHIFT = 34;
   localparam int OFF_U   = 3 << (WW - 2);     // multiple of six, keeps dividend positive
   localparam int OFF_QUO = 1 << (WW - 3);     // OFF_U / 6

endpackage

@@ design/trci_ram.sv @@
// generic single write port, single read port ram with registered read
module trci_ram #(
   parameter int WIDTH = trci_pkg::SAMPLE_BITS,
   parameter int DEPTH = trci_pkg::TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/table_read_cubic_interp.sv @@
// sample table with four-point cubic interpolated reads, eleven stage pipeline
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operation, write_address, write_value,
//                                            read_position
//   rsp      out        rsp_valid/rsp_stall  sample_out
//   csr      in         csr_wr_en            csr_index, csr_wr_data
//
// one item enters per cycle while req_stall is low; a read item passes stages one
// to eleven before it shows on rsp, the depth being set by the three multiplies of
// the cubic and the reciprocal multiply that divides by six
// write items occupy a slot up to stage one, update the table there and leave
// reset clears the valid bits and both registers; table contents stay undefined
// rsp_stall freezes only the stages that are full, so bubbles close up and
// req_stall rises only when all eleven stages hold an item
module table_read_cubic_interp #(
   parameter int TABLE_DEPTH = trci_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_operation,
   input  logic [trci_pkg::WADDR_BITS-1:0]         req_write_address,
   input  logic signed [trci_pkg::SAMPLE_BITS-1:0] req_write_value,
   input  logic signed [trci_pkg::POS_BITS-1:0]    req_read_position,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [trci_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   // configuration writes
   input  logic                                    csr_wr_en,
   input  logic [trci_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [trci_pkg::CSR_DATA_BITS-1:0]      csr_wr_data
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int NST  = 11;                    // pipeline stages
   localparam int NTAP = 4;                     // neighbours a, b, c, d
   localparam int SB   = trci_pkg::SAMPLE_BITS;
   localparam int PB   = trci_pkg::POS_BITS;
   localparam int FB   = trci_pkg::FRAC_BITS;
   localparam int IW   = PB - FB;               // integer part of a position
   localparam int FW   = trci_pkg::FW;
   localparam int DW   = trci_pkg::DW;
   localparam int PQW  = trci_pkg::PQW;
   localparam int P1W  = trci_pkg::P1W;
   localparam int T1W  = trci_pkg::T1W;
   localparam int P2W  = trci_pkg::P2W;
   localparam int WW   = trci_pkg::WW;
   localparam int P3W  = trci_pkg::P3W;
   localparam int UW   = trci_pkg::UW;

   // rounding constants: half an lsb, and half of six lsb for the final divide
   localparam logic signed [P1W-1:0] RND1 = P1W'(trci_pkg::FRAC_HALF);
   localparam logic signed [P2W-1:0] RND2 = P2W'(trci_pkg::FRAC_HALF);
   localparam logic signed [P3W-1:0] RND3 = P3W'(3 * trci_pkg::FRAC_ONE);
   localparam logic signed [P3W-1:0] BIAS_U = P3W'(trci_pkg::OFF_U);
   localparam logic signed [WW-1:0]  BIAS_Q = WW'(trci_pkg::OFF_QUO);
   localparam logic signed [WW-1:0]  SAT_HI = WW'((1 << (SB - 1)) - 1);
   localparam logic signed [WW-1:0]  SAT_LO = WW'(-(1 << (SB - 1)));

   // values that ride along with an item from stage three to the output
   typedef struct packed {
      logic                 zero;   // short table, result forced to zero
      logic signed [SB-1:0] b;
      logic signed [DW-1:0] cb;
      logic [FW-1:0]        frac;
   } side_type;

   // configuration registers
   logic [trci_pkg::PTS_BITS-1:0] pts_ff;
   logic signed [PB-1:0]          onset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff   <= '0;
         onset_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            trci_pkg::CSR_TABLE_POINTS: pts_ff <= csr_wr_data[trci_pkg::PTS_BITS-1:0];
            trci_pkg::CSR_ONSET:        onset_ff <= $signed(csr_wr_data[PB-1:0]);
            default: ;
         endcase
      end
   end

   // flow control: a stage loads when it is empty or its item moves on
   logic [NST:1] vld_ff;
   logic [NST:1] vld_in;
   logic [NST:1] rdy;

   always_comb begin
      rdy[NST] = !vld_ff[NST] || !rsp_stall;
      for (int k = NST - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   // stage one: position plus onset, saturated to the position range
   logic                              op1_ff;
   logic [trci_pkg::WADDR_BITS-1:0]   waddr1_ff;
   logic [SB-1:0]                     wval1_ff;
   logic signed [PB-1:0]              pos1_ff;
   logic signed [PB:0]                pos_sum;
   logic signed [PB-1:0]              pos_sat;

   always_comb begin
      pos_sum = (PB+1)'(req_read_position) + (PB+1)'(onset_ff);
      if (pos_sum[PB] != pos_sum[PB-1]) begin
         pos_sat = pos_sum[PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
      end else begin
         pos_sat = pos_sum[PB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         op1_ff    <= req_operation;
         waddr1_ff <= req_write_address;
         wval1_ff  <= req_write_value;
         pos1_ff   <= pos_sat;
      end
   end

   // stage one to two: index split, clamping, table access
   logic signed [IW-1:0] int1;
   logic signed [31:0]   int_w;
   logic [31:0]          pts_lim;
   logic signed [31:0]   max_idx;
   logic                 short1;
   logic signed [31:0]   idx1;
   logic [FW-1:0]        frac1;
   logic                 ram_we;
   logic [AW-1:0]        rd_addr [NTAP];
   logic [SB-1:0]        rd_data [NTAP];

   always_comb begin
      int1    = pos1_ff[PB-1:FB];
      int_w   = 32'(int1);
      // a point count beyond the table acts as the full table
      pts_lim = (32'(pts_ff) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(pts_ff);
      max_idx = $signed(pts_lim) - 32'sd3;
      short1  = (pts_lim < 32'd3);
      // the low clamp wins over the high clamp
      if (int_w < 32'sd1) begin
         idx1  = 32'sd1;
         frac1 = '0;
      end else if (int_w > max_idx) begin
         idx1  = max_idx;
         frac1 = FW'(trci_pkg::FRAC_ONE);
      end else begin
         idx1  = int_w;
         frac1 = {1'b0, pos1_ff[FB-1:0]};
      end
      // with three points a position at or beyond one gives index zero, and the left neighbor wraps
      rd_addr[0] = (idx1 == 32'sd0) ? AW'(TABLE_DEPTH - 1) : AW'(idx1 - 32'sd1);
      rd_addr[1] = AW'(idx1);
      rd_addr[2] = AW'(idx1 + 32'sd1);
      rd_addr[3] = AW'(idx1 + 32'sd2);
   end

   // writes land at the same stage where reads look, so item order holds
   assign ram_we = vld_ff[1] && (op1_ff == trci_pkg::OP_WRITE) && rdy[2]
                   && (32'(waddr1_ff) < 32'(TABLE_DEPTH));

   // four copies of the table, one per neighbour, all written together
   for (genvar g = 0; g < NTAP; g++) begin : g_bank
      trci_ram #(
         .WIDTH (SB),
         .DEPTH (TABLE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we),
         .wr_addr (AW'(waddr1_ff)),
         .wr_data (wval1_ff),
         .rd_en   (rdy[2]),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   // stage two: neighbours come out of the ram registers
   logic [FW-1:0] frac2_ff;
   logic          zero2_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         frac2_ff <= frac1;
         zero2_ff <= short1;
      end
   end

   // stage three: cubic coefficients
   logic signed [SB-1:0]  da, db, dc, dd;
   logic signed [DW-1:0]  cb3;
   logic signed [PQW-1:0] cb3_x;
   logic signed [PQW-1:0] p3_in, q3_in;
   logic signed [PQW-1:0] p3_ff, q3_ff;
   side_type              side_ff [3:NST];
   side_type              side3_in;

   always_comb begin
      da    = $signed(rd_data[0]);
      db    = $signed(rd_data[1]);
      dc    = $signed(rd_data[2]);
      dd    = $signed(rd_data[3]);
      cb3   = DW'(dc) - DW'(db);
      cb3_x = PQW'(cb3);
      // p = d - a - 3(c-b), q = d + 2a - 3b
      p3_in = PQW'(dd) - PQW'(da) - (cb3_x + (cb3_x <<< 1));
      q3_in = PQW'(dd) + (PQW'(da) <<< 1) - (PQW'(db) + (PQW'(db) <<< 1));
      side3_in = '{zero: zero2_ff, b: db, cb: cb3, frac: frac2_ff};
   end

   // later stage signals
   logic signed [P1W-1:0] m1_in, m1_ff;
   logic signed [PQW-1:0] q4_ff;
   logic signed [T1W-1:0] t1_in, t1_ff;
   logic [FW-1:0]         onef;
   logic signed [P2W-1:0] m2_in, m2_ff;
   logic signed [P2W-1:0] t2;
   logic signed [WW-1:0]  cb_w;
   logic signed [WW-1:0]  w_in, w_ff;
   logic signed [P3W-1:0] m3_in, m3_ff;
   logic signed [P3W-1:0] y9;
   logic [UW-1:0]         u_in, u_ff;
   logic [UW+31:0]        m4_in, m4_ff;
   logic signed [WW-1:0]  quo, total;
   logic signed [SB-1:0]  out_in, out_ff;

   always_comb begin
      // p * frac
      m1_in = p3_ff * $signed({1'b0, side_ff[3].frac});
      // t1 = q + round(p * frac)
      t1_in = T1W'(q4_ff) + T1W'((m1_ff + RND1) >>> FB);
      // t1 * (1 - frac)
      onef  = FW'(trci_pkg::FRAC_ONE) - side_ff[5].frac;
      m2_in = t1_ff * $signed({1'b0, onef});
      // w = 6(c-b) - round(t1 * (1 - frac))
      t2    = (m2_ff + RND2) >>> FB;
      cb_w  = WW'($signed(side_ff[6].cb));
      w_in  = (cb_w <<< 2) + (cb_w <<< 1) - WW'(t2);
      // frac * w
      m3_in = w_ff * $signed({1'b0, side_ff[7].frac});
      // divide by the fraction scale with rounding, bias positive for the divide by six
      y9    = (m3_ff + RND3) >>> FB;
      u_in  = UW'(y9 + BIAS_U);
      // divide by six through the reciprocal
      m4_in = u_ff * trci_pkg::MAGIC6;
      // remove the bias, add b, saturate, or give zero for a short table
      quo   = $signed(WW'(m4_ff >> trci_pkg::MAGIC_SHIFT)) - BIAS_Q;
      total = quo + WW'($signed(side_ff[10].b));
      if (side_ff[10].zero) begin
         out_in = '0;
      end else if (total > SAT_HI) begin
         out_in = SAT_HI[SB-1:0];
      end else if (total < SAT_LO) begin
         out_in = SAT_LO[SB-1:0];
      end else begin
         out_in = total[SB-1:0];
      end
   end

   // payload registers, each loaded when its stage can take an item
   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         p3_ff      <= p3_in;
         q3_ff      <= q3_in;
         side_ff[3] <= side3_in;
      end
      for (int k = 4; k <= NST; k++) begin
         if (rdy[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
      if (rdy[4]) begin
         m1_ff <= m1_in;
         q4_ff <= q3_ff;
      end
      if (rdy[5]) begin
         t1_ff <= t1_in;
      end
      if (rdy[6]) begin
         m2_ff <= m2_in;
      end
      if (rdy[7]) begin
         w_ff <= w_in;
      end
      if (rdy[8]) begin
         m3_ff <= m3_in;
      end
      if (rdy[9]) begin
         u_ff <= u_in;
      end
      if (rdy[10]) begin
         m4_ff <= m4_in;
      end
      if (rdy[11]) begin
         out_ff <= out_in;
      end
   end

   // valid bits travel with the data; write items drop out after stage one
   always_comb begin
      vld_in[1] = req_valid;
      vld_in[2] = vld_ff[1] && (op1_ff == trci_pkg::OP_READ);
      for (int k = 3; k <= NST; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NST; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_stall      = !rdy[1];
   assign rsp_valid      = vld_ff[NST];
   assign rsp_sample_out = out_ff;

   // input backs up only when every stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("request stalled with a bubble in the pipeline");

   // clamped fraction never exceeds one
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (frac2_ff <= FW'(trci_pkg::FRAC_ONE)))
      else $error("fraction out of range at table output");

   // a short table always reads as zero
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && side_ff[NST].zero) |-> (rsp_sample_out == '0))
      else $error("short table gave a nonzero sample");

endmodule
